### src/sti_pkg.sv
// Package for the sorted table insert / interval block.
// Holds the request and result types, sizes and status codes.
// Used by the top level and the checker; depends on nothing.
package sti_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int INDEX_W     = 7;
    localparam int FILL_W      = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic                          kind;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          adj;
    } req_t;

    typedef struct packed {
        logic signed [INDEX_W-1:0] index;
        logic [FILL_W-1:0]         fill;
        logic [1:0]                status;
    } res_t;

endpackage

### src/sti_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Self-contained; no package needed.
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/sorted_table_insert_interval.sv
// Top level of the sorted table: sequencer, search registers and table RAM.
// Depends on sti_pkg and sti_ram.
//
//   Channel | Signals                       | Direction | Payload
//   request | req_valid, req_ready, req     | in        | sti_pkg::req_t (kind, value, adj)
//   result  | res_valid, res_ready, res     | out       | sti_pkg::res_t (index, fill, status)
//
// One request is worked on at a time, and req_ready is high only while the sequencer is idle.
// An empty query or a full or first insert goes straight to S_DONE. Else the last entry is read:
// a query at or above it, or an insert above or equal to it, is done. Else the first entry is read:
// a query below it is done, an insert below it moves every entry up; else a binary search runs,
// and a new insert then moves the entries above its place up one by one before it is written.
// Reset clears the count, sequencer and result valid; a stalled result holds the next one in S_DONE.
module sorted_table_insert_interval (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sti_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output sti_pkg::res_t res
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;  // waiting for a request
    localparam logic [3:0] S_LAST  = 4'd1;  // last entry read back
    localparam logic [3:0] S_FIRST = 4'd2;  // first entry read back
    localparam logic [3:0] S_SRCH  = 4'd3;  // decide next search step
    localparam logic [3:0] S_CMP   = 4'd4;  // middle entry read back
    localparam logic [3:0] S_SHRD  = 4'd5;  // read an entry to move up
    localparam logic [3:0] S_SHWR  = 4'd6;  // write it one place higher
    localparam logic [3:0] S_WKEY  = 4'd7;  // write the new value
    localparam logic [3:0] S_DONE  = 4'd8;  // pass result to the output register

    logic [3:0] state_reg, state_next;

    logic                                   kind_reg, kind_next;
    logic signed [sti_pkg::VALUE_WIDTH-1:0] value_reg, value_next;
    logic                                   adj_reg, adj_next;
    logic [sti_pkg::ADDR_W-1:0]             lo_reg, lo_next;
    logic [sti_pkg::ADDR_W-1:0]             hi_reg, hi_next;
    logic [sti_pkg::ADDR_W-1:0]             mid_reg, mid_next;
    logic                                   lo_eq_reg, lo_eq_next;
    logic [sti_pkg::ADDR_W-1:0]             sh_reg, sh_next;
    logic [sti_pkg::ADDR_W-1:0]             pos_reg, pos_next;
    logic [sti_pkg::CNT_W-1:0]              count_reg, count_next;
    logic signed [sti_pkg::INDEX_W-1:0]     idx_reg, idx_next;
    logic [1:0]                             stat_reg, stat_next;
    sti_pkg::res_t                          res_reg, res_next;
    logic                                   res_valid_reg, res_valid_next;

    // RAM port signals.
    logic                            ram_we;
    logic [sti_pkg::ADDR_W-1:0]      ram_waddr;
    logic [sti_pkg::VALUE_WIDTH-1:0] ram_wdata;
    logic [sti_pkg::ADDR_W-1:0]      ram_raddr;
    logic [sti_pkg::VALUE_WIDTH-1:0] ram_rdata;

    logic signed [sti_pkg::VALUE_WIDTH-1:0] rd_val;
    logic [sti_pkg::CNT_W-1:0]              cnt_m1;
    logic [sti_pkg::ADDR_W:0]               mid_sum;
    logic                                   req_acc;

    sti_ram #(
        .WIDTH (sti_pkg::VALUE_WIDTH),
        .DEPTH (sti_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign rd_val  = $signed(ram_rdata);
    assign cnt_m1  = count_reg - sti_pkg::CNT_W'(1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        adj_next       = adj_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lo_eq_next     = lo_eq_reg;
        sh_next        = sh_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[sti_pkg::ADDR_W-1:0];
        ram_wdata = value_reg;
        ram_raddr = cnt_m1[sti_pkg::ADDR_W-1:0];

        // The output register empties when the downstream side takes the result.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // The read of the last entry is issued here in any case; it is only
                // used when the request goes on to S_LAST.
                ram_raddr = cnt_m1[sti_pkg::ADDR_W-1:0];
                if (req_acc)
                begin
                    kind_next  = req.kind;
                    value_next = req.value;
                    adj_next   = req.adj;
                    idx_next   = '0;
                    stat_next  = sti_pkg::ST_OK;
                    if (req.kind == sti_pkg::KIND_QUERY && count_reg == '0)
                    begin
                        stat_next  = sti_pkg::ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else if (req.kind == sti_pkg::KIND_INSERT &&
                             count_reg == sti_pkg::CNT_W'(sti_pkg::DEPTH))
                    begin
                        stat_next  = sti_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (req.kind == sti_pkg::KIND_INSERT && count_reg == '0)
                    begin
                        // First value into an empty table.
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = req.value;
                        count_next = sti_pkg::CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
            end

            S_LAST:
            begin
                ram_raddr = '0;
                if (kind_reg == sti_pkg::KIND_QUERY)
                begin
                    if (value_reg >= rd_val)
                    begin
                        // At or above the last entry: clamp to the top interval.
                        idx_next = adj_reg
                            ? $signed(sti_pkg::INDEX_W'(count_reg) - sti_pkg::INDEX_W'(1))
                            : $signed(sti_pkg::INDEX_W'(count_reg) - sti_pkg::INDEX_W'(2));
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIRST;
                    end
                end
                else if (value_reg > rd_val)
                begin
                    // Larger than everything stored: append at the top.
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[sti_pkg::ADDR_W-1:0];
                    idx_next   = $signed(sti_pkg::INDEX_W'(count_reg));
                    count_next = count_reg + sti_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
                else if (value_reg == rd_val)
                begin
                    stat_next  = sti_pkg::ST_DUP;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIRST;
                end
            end

            S_FIRST:
            begin
                lo_next    = '0;
                hi_next    = cnt_m1[sti_pkg::ADDR_W-1:0];
                lo_eq_next = (value_reg == rd_val);
                if (value_reg < rd_val)
                begin
                    if (kind_reg == sti_pkg::KIND_QUERY)
                    begin
                        idx_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Below the first entry: everything moves up one place.
                        pos_next   = '0;
                        sh_next    = cnt_m1[sti_pkg::ADDR_W-1:0];
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    state_next = S_SRCH;
                end
            end

            S_SRCH:
            begin
                mid_next  = mid_sum[sti_pkg::ADDR_W:1];
                ram_raddr = mid_sum[sti_pkg::ADDR_W:1];
                if ({1'b0, hi_reg} > ({1'b0, lo_reg} + (sti_pkg::ADDR_W + 1)'(1)))
                begin
                    state_next = S_CMP;
                end
                else if (kind_reg == sti_pkg::KIND_QUERY)
                begin
                    idx_next   = $signed(sti_pkg::INDEX_W'(lo_reg));
                    state_next = S_DONE;
                end
                else if (lo_eq_reg)
                begin
                    stat_next  = sti_pkg::ST_DUP;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = lo_reg + sti_pkg::ADDR_W'(1);
                    sh_next    = cnt_m1[sti_pkg::ADDR_W-1:0];
                    state_next = S_SHRD;
                end
            end

            S_CMP:
            begin
                if (value_reg < rd_val)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next    = mid_reg;
                    lo_eq_next = (value_reg == rd_val);
                end
                state_next = S_SRCH;
            end

            S_SHRD:
            begin
                ram_raddr  = sh_reg;
                state_next = S_SHWR;
            end

            S_SHWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sh_reg + sti_pkg::ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (sh_reg == pos_reg)
                begin
                    state_next = S_WKEY;
                end
                else
                begin
                    sh_next    = sh_reg - sti_pkg::ADDR_W'(1);
                    state_next = S_SHRD;
                end
            end

            S_WKEY:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = value_reg;
                idx_next   = $signed(sti_pkg::INDEX_W'(pos_reg));
                count_next = count_reg + sti_pkg::CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand over once the output register is free or being emptied.
                if (!res_valid_reg || res_ready)
                begin
                    res_next.index  = idx_reg;
                    res_next.fill   = sti_pkg::FILL_W'(count_reg);
                    res_next.status = stat_reg;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        adj_reg   <= adj_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        lo_eq_reg <= lo_eq_next;
        sh_reg    <= sh_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
    end

endmodule

### src/sti_checker.sv
// Port-level checker for the sorted table block, bound to its top level.
// Depends on sti_pkg and sorted_table_insert_interval.
module sti_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input sti_pkg::req_t req,
    input logic          res_valid,
    input logic          res_ready,
    input sti_pkg::res_t res
);

    // A stalled result keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A query on an empty table reports an empty table and index zero.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == sti_pkg::ST_EMPTY |-> res.fill == '0 && res.index == '0)
        else $error("empty status with entries");

    // A dropped insert only happens with a full table.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == sti_pkg::ST_FULL
        |-> res.fill == sti_pkg::FILL_W'(sti_pkg::DEPTH) && res.index == '0)
        else $error("full status below depth");

    // A successful or duplicate result always sees at least one entry.
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == sti_pkg::ST_OK || res.status == sti_pkg::ST_DUP)
        |-> res.fill != '0)
        else $error("ok status with empty table");

endmodule

bind sorted_table_insert_interval sti_port_checker u_sti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
